@@ hw/rtl/wavg_pkg.sv @@
// wavg_pkg: shared sizes, opcodes, state enums and structs for the weighted
// average accumulator. No dependencies; used by wavg_readout and the core.
package wavg_pkg;

  localparam int unsigned ELEMENTS = 4096;
  localparam int unsigned ADDR_W   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned CMP_W    = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned ENTRY_W  = SUM_W + TOTAL_W;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned DIV_STEPS = 16;

  localparam logic [DATA_W-1:0] SCALE_RESET = 16'd256;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_RD_WAIT,
    ST_RD_CALC,
    ST_RD_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_MUL,
    RS_NUM,
    RS_CHK,
    RS_DIV,
    RS_RND
  } rdo_state_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] total;
  } rdo_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] average;
  } rdo_result_t;

endpackage

@@ hw/rtl/wavg_ram.sv @@
// wavg_ram: generic single-write, single-read synchronous ram, registered read.
// Standalone; no package dependency.
module wavg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/wavg_readout.sv @@
// wavg_readout: scaled rounded quotient (sum*scale)/(total*256), saturated.
// Split multiply, then a one-bit-per-cycle restoring divider. Uses wavg_pkg.
module wavg_readout (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wavg_pkg::rdo_req_t            req,
  input  logic [wavg_pkg::DATA_W-1:0]   scale,
  output wavg_pkg::rdo_result_t         res
);

  wavg_pkg::rdo_state_t state_r, state_nxt;

  logic [wavg_pkg::SUM_W-1:0]   sum_r;
  logic [wavg_pkg::TOTAL_W-1:0] tot_r;
  logic [39:0]                  pp_lo_r, pp_hi_r;
  logic [63:0]                  num_r;
  logic [39:0]                  den_r;
  logic [39:0]                  rem_r;
  logic [15:0]                  quo_r;
  logic [3:0]                   cnt_r;

  logic                         done_r, done_nxt;
  logic [wavg_pkg::DATA_W-1:0]  avg_r, avg_nxt;

  logic [40:0] trial;
  logic [40:0] diff;
  logic        trial_ge;
  logic        too_big;
  logic        round_up;
  logic [16:0] rounded;

  // divider step and final checks
  always_comb begin
    trial    = {rem_r, quo_r[15]};
    trial_ge = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
    too_big  = num_r >= {8'b0, den_r, 16'b0};
    round_up = {rem_r, 1'b0} >= {1'b0, den_r};
    rounded  = {1'b0, quo_r} + {16'b0, round_up};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wavg_pkg::RS_IDLE: begin
        if (req.start && (req.total != '0)) begin
          state_nxt = wavg_pkg::RS_MUL;
        end
      end
      wavg_pkg::RS_MUL: state_nxt = wavg_pkg::RS_NUM;
      wavg_pkg::RS_NUM: state_nxt = wavg_pkg::RS_CHK;
      wavg_pkg::RS_CHK: begin
        state_nxt = too_big ? wavg_pkg::RS_IDLE : wavg_pkg::RS_DIV;
      end
      wavg_pkg::RS_DIV: begin
        if (cnt_r == 4'(wavg_pkg::DIV_STEPS - 1)) begin
          state_nxt = wavg_pkg::RS_RND;
        end
      end
      wavg_pkg::RS_RND: state_nxt = wavg_pkg::RS_IDLE;
      default:          state_nxt = wavg_pkg::RS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_nxt = 1'b0;
    avg_nxt  = '0;
    case (state_r)
      wavg_pkg::RS_IDLE: begin
        if (req.start && (req.total == '0)) begin
          done_nxt = 1'b1;
        end
      end
      wavg_pkg::RS_CHK: begin
        if (too_big) begin
          done_nxt = 1'b1;
          avg_nxt  = '1;
        end
      end
      wavg_pkg::RS_RND: begin
        done_nxt = 1'b1;
        avg_nxt  = rounded[16] ? '1 : rounded[15:0];
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wavg_pkg::RS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done_nxt) begin
      avg_r <= avg_nxt;
    end
    case (state_r)
      wavg_pkg::RS_IDLE: begin
        sum_r <= req.sum;
        tot_r <= req.total;
      end
      wavg_pkg::RS_MUL: begin
        pp_lo_r <= {16'b0, sum_r[23:0]} * {24'b0, scale};
        pp_hi_r <= {16'b0, sum_r[47:24]} * {24'b0, scale};
      end
      wavg_pkg::RS_NUM: begin
        num_r <= {pp_hi_r, 24'b0} + {24'b0, pp_lo_r};
        den_r <= {tot_r, 8'b0};
      end
      wavg_pkg::RS_CHK: begin
        // below the saturation bound the high part is already smaller than den
        rem_r <= num_r[55:16];
        quo_r <= num_r[15:0];
        cnt_r <= '0;
      end
      wavg_pkg::RS_DIV: begin
        rem_r <= trial_ge ? diff[39:0] : trial[39:0];
        quo_r <= {quo_r[14:0], trial_ge};
        cnt_r <= cnt_r + 4'd1;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign res = {done_r, avg_r};

endmodule

@@ hw/rtl/weighted_average_accumulator_core.sv @@
// weighted_average_accumulator_core: top level, element store, control sequencer,
// add update, clear sweep, frame counter and result register.
// Depends on wavg_pkg, wavg_ram and wavg_readout.
//
//   channel  direction  handshake             payload
//   in_      to block   in_valid / in_stall   opcode, element_index, sample,
//                                             weight, frame_end
//   out_     from block out_valid / out_stall average, has_weight, frame_count
//   cfg_     to block   cfg_wr_en             cfg_wr_data (scale, Q8.8)
//
// an add reads the element entry, then does a saturating write back
// a read runs the split multiply, then the one-bit-per-cycle divider (16 steps);
// it ends early when the quotient is known to clip, or for an element with no
// weight; a stalled result holds the sequencer in ST_RD_OUT
// a clear, and the sweep after reset, zero all ELEMENTS (4096) entries, one entry
// a cycle; in_stall stays high meanwhile, config writes are still taken
// the result sits in an output register, so new beats are taken while it waits

module weighted_average_accumulator_core (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [wavg_pkg::IDX_W-1:0]    in_element_index,
  input  logic [15:0]                   in_sample,
  input  logic [15:0]                   in_weight,
  input  logic                          in_frame_end,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wavg_pkg::DATA_W-1:0]   out_average,
  output logic                          out_has_weight,
  output logic [wavg_pkg::FRAME_W-1:0]  out_frame_count,

  input  logic                          cfg_wr_en,
  input  logic [wavg_pkg::DATA_W-1:0]   cfg_wr_data
);

  wavg_pkg::ctl_state_t state_r, state_nxt;

  // control registers
  wavg_pkg::addr_t               clr_addr_r, clr_addr_nxt;
  logic [wavg_pkg::FRAME_W-1:0]  frames_r, frames_nxt;
  logic [wavg_pkg::DATA_W-1:0]   scale_r;
  logic                          out_valid_r;

  // per-beat payload registers
  wavg_pkg::addr_t               addr_r;
  logic                          in_range_r;
  logic [31:0]                   product_r;
  logic [15:0]                   weight_r;
  logic                          hw_r;
  logic [wavg_pkg::DATA_W-1:0]   avg_hold_r;
  logic [wavg_pkg::DATA_W-1:0]   out_avg_r;
  logic                          out_hw_r;
  logic [wavg_pkg::FRAME_W-1:0]  out_fc_r;

  logic                          in_accept;
  logic                          in_range;
  logic                          out_free;
  logic                          load_out;

  // element store: {weighted sum, weight total}
  logic                          ram_we;
  wavg_pkg::addr_t               ram_waddr;
  logic [wavg_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [wavg_pkg::ENTRY_W-1:0]  ram_rdata;

  // add update
  logic [wavg_pkg::SUM_W:0]      sum_add;
  logic [wavg_pkg::TOTAL_W:0]    tot_add;
  logic [wavg_pkg::SUM_W-1:0]    sum_sat;
  logic [wavg_pkg::TOTAL_W-1:0]  tot_sat;

  wavg_pkg::rdo_req_t            rdo_req;
  wavg_pkg::rdo_result_t         rdo_res;

  assign in_accept = in_valid && !in_stall;
  assign in_range  = wavg_pkg::cmp_t'(in_element_index) < wavg_pkg::cmp_t'(wavg_pkg::ELEMENTS);
  assign out_free  = !out_valid_r || !out_stall;

  // saturating accumulate of the stored entry
  always_comb begin
    sum_add = {1'b0, ram_rdata[wavg_pkg::ENTRY_W-1:wavg_pkg::TOTAL_W]}
            + {17'b0, product_r};
    tot_add = {1'b0, ram_rdata[wavg_pkg::TOTAL_W-1:0]} + {17'b0, weight_r};
    sum_sat = sum_add[wavg_pkg::SUM_W] ? '1 : sum_add[wavg_pkg::SUM_W-1:0];
    tot_sat = tot_add[wavg_pkg::TOTAL_W] ? '1 : tot_add[wavg_pkg::TOTAL_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wavg_pkg::ST_CLEAR: begin
        if (clr_addr_r == wavg_pkg::addr_t'(wavg_pkg::ELEMENTS - 1)) begin
          state_nxt = wavg_pkg::ST_IDLE;
        end
      end
      wavg_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_opcode)
            wavg_pkg::OP_ADD:   state_nxt = wavg_pkg::ST_ADD_WR;
            wavg_pkg::OP_READ:  state_nxt = wavg_pkg::ST_RD_WAIT;
            wavg_pkg::OP_CLEAR: state_nxt = wavg_pkg::ST_CLEAR;
            default:            state_nxt = wavg_pkg::ST_IDLE;
          endcase
        end
      end
      wavg_pkg::ST_ADD_WR:  state_nxt = wavg_pkg::ST_IDLE;
      wavg_pkg::ST_RD_WAIT: state_nxt = wavg_pkg::ST_RD_CALC;
      wavg_pkg::ST_RD_CALC: begin
        if (rdo_res.done) begin
          state_nxt = wavg_pkg::ST_RD_OUT;
        end
      end
      wavg_pkg::ST_RD_OUT: begin
        if (out_free) begin
          state_nxt = wavg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wavg_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {sum_sat, tot_sat};
    load_out  = 1'b0;
    rdo_req.start = 1'b0;
    rdo_req.sum   = ram_rdata[wavg_pkg::ENTRY_W-1:wavg_pkg::TOTAL_W];
    // an out-of-range read looks like an element with no weight
    rdo_req.total = in_range_r ? ram_rdata[wavg_pkg::TOTAL_W-1:0] : '0;
    case (state_r)
      wavg_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      wavg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      wavg_pkg::ST_ADD_WR: begin
        // out-of-range adds only touch the frame counter
        ram_we = in_range_r;
      end
      wavg_pkg::ST_RD_WAIT: begin
        rdo_req.start = 1'b1;
      end
      wavg_pkg::ST_RD_OUT: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // clear sweep address and frame counter
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    frames_nxt   = frames_r;
    if (state_r == wavg_pkg::ST_CLEAR) begin
      clr_addr_nxt = clr_addr_r + wavg_pkg::addr_t'(1);
    end
    if (in_accept && (in_opcode == wavg_pkg::OP_CLEAR)) begin
      clr_addr_nxt = '0;
      frames_nxt   = '0;
    end
    if (in_accept && (in_opcode == wavg_pkg::OP_ADD) && in_frame_end &&
        (frames_r != '1)) begin
      frames_nxt = frames_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wavg_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      frames_r    <= '0;
      scale_r     <= wavg_pkg::SCALE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      frames_r   <= frames_nxt;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // beat payload capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_r     <= wavg_pkg::addr_t'(in_element_index);
      in_range_r <= in_range;
      product_r  <= {16'b0, in_sample} * {16'b0, in_weight};
      weight_r   <= in_weight;
    end
    if (state_r == wavg_pkg::ST_RD_WAIT) begin
      hw_r <= rdo_req.total != '0;
    end
    if ((state_r == wavg_pkg::ST_RD_CALC) && rdo_res.done) begin
      avg_hold_r <= rdo_res.average;
    end
    if (load_out) begin
      out_avg_r <= avg_hold_r;
      out_hw_r  <= hw_r;
      out_fc_r  <= frames_r;
    end
  end

  wavg_ram #(
    .WIDTH (wavg_pkg::ENTRY_W),
    .DEPTH (wavg_pkg::ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (wavg_pkg::addr_t'(in_element_index)),
    .rdata (ram_rdata)
  );

  wavg_readout u_readout (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rdo_req),
    .scale (scale_r),
    .res   (rdo_res)
  );

  assign out_valid       = out_valid_r;
  assign out_average     = out_avg_r;
  assign out_has_weight  = out_hw_r;
  assign out_frame_count = out_fc_r;

endmodule
